// File: hdl/aids_pkg.sv
// ----------------------------------------------------------------------------
// aids_pkg
// Shared types and constants for the ordered word store with insert, delete,
// traverse and linear search.
// ----------------------------------------------------------------------------
`default_nettype none

package aids_pkg;

    // Fixed field widths of the stream words
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    // Packed widths of the stream buses
    localparam int S_DATA_W = 40;  // data_value, position, zero pad
    localparam int M_DATA_W = 48;  // item_value, item_index, fill_count, zero pad

    // Action carried in the input tuser
    typedef enum logic [1:0] {
        ACT_TRAVERSE = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_DELETE   = 2'd2,
        ACT_SEARCH   = 2'd3
    } t_action;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_REJECT = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_TR_RD,
        S_TR_OUT,
        S_INS_RD,
        S_INS_WR,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_SR_RD,
        S_SR_CMP
    } t_state;

endpackage

`default_nettype wire

// File: hdl/array_insert_delete_search_core.sv
// ----------------------------------------------------------------------------
// array_insert_delete_search_core
// Ordered store of up to DEPTH signed words with traverse, insert, delete
// and linear search, run by a small sequencer over one RAM port pair.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per action. tuser holds the action, tdata holds
//   the value (or search key) and the position.
//   Master stream: result words. tuser holds the status, tlast marks the
//   final result of an action. A traverse gives one word per stored entry
//   (one word with empty status when the store is empty); every other
//   action gives exactly one word. The shifting is one RAM read and one
//   RAM write per moved entry. The slave side is ready only while idle.
//   A finished result sits in the output register; while the receiver
//   stalls, the sequencer holds its next result and waits.
//   Reset empties the store (fill count zero); the RAM needs no clearing,
//   since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module array_insert_delete_search_core
    import aids_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Action input
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,  // data_value[31:0], position[38:32]
    input  wire logic [1:0]          i_s_axis_tuser,  // action[1:0]
    // Result output
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,  // item_value[31:0], item_index[37:32],
                                                      // fill_count[44:38]
    output logic [1:0]               o_m_axis_tuser,  // status[1:0]
    output logic                     o_m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer and store control
    t_state          r_state,  n_state;
    logic [CW-1:0]   r_count,  n_count;
    logic [CW-1:0]   r_idx,    n_idx;
    logic [CW-1:0]   r_pos,    n_pos;
    logic [VAL_W-1:0] r_key,   n_key;

    // Pending single result
    logic [VAL_W-1:0] r_res_value, n_res_value;
    logic [IDX_W-1:0] r_res_index, n_res_index;
    t_status          r_res_status, n_res_status;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    t_status          r_out_status, n_out_status;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic             r_out_last,  n_out_last;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_wr_addr;
    logic [VAL_W-1:0] ram_wr_data;
    logic             ram_re;
    logic [AW-1:0]    ram_rd_addr;
    logic [VAL_W-1:0] ram_rd_data;

    // Shared index step unit
    logic [CW:0]      idx_inc;
    logic [CW-1:0]    idx_dec;
    logic             out_free;

    // Input fields
    t_action          in_action;
    logic [VAL_W-1:0] in_value;
    logic [POS_W-1:0] in_pos;
    logic [POS_W-1:0] count_ext;

    assign in_action = t_action'(i_s_axis_tuser);
    assign in_value  = i_s_axis_tdata[VAL_W-1:0];
    assign in_pos    = i_s_axis_tdata[VAL_W +: POS_W];
    assign count_ext = POS_W'(r_count);

    assign idx_inc  = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};
    assign idx_dec  = r_idx - {{(CW-1){1'b0}}, 1'b1};
    assign out_free = !r_out_valid || i_m_axis_tready;

    aids_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_re      (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Next state, RAM control and result assembly
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_key        = r_key;
        n_res_value  = r_res_value;
        n_res_index  = r_res_index;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_wr_addr  = r_idx[AW-1:0];
        ram_wr_data  = ram_rd_data;
        ram_re       = 1'b0;
        ram_rd_addr  = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                // Accept an action and set up its walk
                if (i_s_axis_tvalid) begin
                    n_key        = in_value;
                    n_res_value  = '0;
                    n_res_index  = '0;
                    n_res_status = ST_REJECT;
                    n_idx        = '0;
                    n_pos        = r_pos;
                    unique case (in_action)
                        ACT_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_TR_RD;
                            end
                        end
                        ACT_INSERT: begin
                            if (r_count >= CW'(DEPTH) || in_pos > count_ext) begin
                                n_state = S_EMIT;
                            end else begin
                                n_pos   = CW'(in_pos);
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_DELETE: begin
                            if (in_pos >= count_ext) begin
                                n_state = S_EMIT;
                            end else begin
                                n_pos       = CW'(in_pos);
                                n_idx       = CW'(in_pos);
                                ram_re      = 1'b1;
                                ram_rd_addr = in_pos[AW-1:0];
                                n_state     = S_DEL_CAP;
                            end
                        end
                        ACT_SEARCH: begin
                            n_state = S_SR_RD;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                // Hand the single result to the output register
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_index  = r_res_index;
                    n_out_status = r_res_status;
                    n_out_count  = CNT_W'(r_count);
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            S_TR_RD: begin
                ram_re  = 1'b1;
                n_state = S_TR_OUT;
            end

            S_TR_OUT: begin
                // Emit one stored word, advance or finish
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = ram_rd_data;
                    n_out_index  = IDX_W'(r_idx);
                    n_out_status = ST_OK;
                    n_out_count  = CNT_W'(r_count);
                    n_out_last   = (idx_inc == {1'b0, r_count});
                    if (idx_inc == {1'b0, r_count}) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc[CW-1:0];
                        n_state = S_TR_RD;
                    end
                end
            end

            S_INS_RD: begin
                // Fetch the entry below the hole, or drop the new word in
                if (r_idx > r_pos) begin
                    ram_re      = 1'b1;
                    ram_rd_addr = idx_dec[AW-1:0];
                    n_state     = S_INS_WR;
                end else begin
                    ram_we       = 1'b1;
                    ram_wr_addr  = r_pos[AW-1:0];
                    ram_wr_data  = r_key;
                    n_count      = r_count + {{(CW-1){1'b0}}, 1'b1};
                    n_res_value  = r_key;
                    n_res_index  = IDX_W'(r_pos);
                    n_res_status = ST_OK;
                    n_state      = S_EMIT;
                end
            end

            S_INS_WR: begin
                // Move the fetched entry up by one
                ram_we  = 1'b1;
                n_idx   = idx_dec;
                n_state = S_INS_RD;
            end

            S_DEL_CAP: begin
                // Keep the removed word
                n_res_value = ram_rd_data;
                n_res_index = IDX_W'(r_pos);
                n_state     = S_DEL_RD;
            end

            S_DEL_RD: begin
                // Fetch the entry above the hole, or close out
                if (idx_inc < {1'b0, r_count}) begin
                    ram_re      = 1'b1;
                    ram_rd_addr = idx_inc[AW-1:0];
                    n_state     = S_DEL_WR;
                end else begin
                    n_count      = r_count - {{(CW-1){1'b0}}, 1'b1};
                    n_res_status = ST_OK;
                    n_state      = S_EMIT;
                end
            end

            S_DEL_WR: begin
                // Move the fetched entry down by one
                ram_we  = 1'b1;
                n_idx   = idx_inc[CW-1:0];
                n_state = S_DEL_RD;
            end

            S_SR_RD: begin
                if (r_idx < r_count) begin
                    ram_re  = 1'b1;
                    n_state = S_SR_CMP;
                end else begin
                    n_res_status = ST_MISS;
                    n_state      = S_EMIT;
                end
            end

            S_SR_CMP: begin
                // Compare one entry with the key
                if (ram_rd_data == r_key) begin
                    n_res_value  = r_key;
                    n_res_index  = IDX_W'(r_idx);
                    n_res_status = ST_OK;
                    n_state      = S_EMIT;
                end else begin
                    n_idx   = idx_inc[CW-1:0];
                    n_state = S_SR_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_res_value  <= n_res_value;
        r_res_index  <= n_res_index;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_index  <= n_out_index;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    // Ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_DATA_W - VAL_W - IDX_W - CNT_W){1'b0}},
                              r_out_count, r_out_index, r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // Fill count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count)))
        else $error("fill count jumped");

    // RAM writes happen only while shifting or placing a word
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INS_RD) || (r_state == S_INS_WR) || (r_state == S_DEL_WR))
        else $error("RAM write outside insert or delete");

    // Only a traverse result may leave tlast low
    a_open_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> (r_out_status == ST_OK))
        else $error("open run with non-ok status");

    // The slave side is closed while a result is pending in the sequencer
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_s_axis_tready)
        else $error("ready while emitting");

endmodule

`default_nettype wire

// File: hdl/aids_ram.sv
// ----------------------------------------------------------------------------
// aids_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs array_insert_delete_search_core through traverse, insert, delete and
// search words. A behavioral copy of the store inside this bench predicts
// every result word as soon as an action word is accepted. A monitor checks
// the master stream field by field against the oldest prediction. The run
// covers the empty store, edge values, a full store, and random mixes under
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;
    import aids_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 200;
    localparam int RESET_CYCLES  = 11;

    // One result word, split into its fields
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        t_status          status;
        logic [CNT_W-1:0] fill;
        logic             last;
    } t_result;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;  // data_value[31:0], position[38:32]
    logic [1:0]          i_s_axis_tuser  = '0;  // action[1:0]
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;        // item_value[31:0], item_index[37:32],
                                                // fill_count[44:38]
    logic [1:0]          o_m_axis_tuser;        // status[1:0]
    logic                o_m_axis_tlast;

    // Shadow copy of the store and the results it predicts
    logic [VAL_W-1:0] store_words [STORE_DEPTH];
    int unsigned      store_count = 0;
    t_result          result_queue [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    array_insert_delete_search_core #(
        .DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Stall the receiver at random
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up well past the slowest legal run
    initial begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Apply one action to the shadow store and queue the words it yields
    task automatic apply_action(t_action act, logic [VAL_W-1:0] val,
                                logic [POS_W-1:0] pos);
        t_result     res;
        int unsigned i;
        bit          hit;
        res.value  = '0;
        res.index  = '0;
        res.status = ST_OK;
        res.fill   = '0;
        res.last   = 1'b1;
        hit        = 1'b0;
        case (act)
            ACT_TRAVERSE: begin
                if (store_count == 0) begin
                    res.status = ST_EMPTY;
                    result_queue.push_back(res);
                end else begin
                    for (i = 0; i < store_count; i++) begin
                        res.value = store_words[i];
                        res.index = IDX_W'(i);
                        res.fill  = CNT_W'(store_count);
                        res.last  = (i + 1 == store_count);
                        result_queue.push_back(res);
                    end
                end
            end
            ACT_INSERT: begin
                if (store_count >= STORE_DEPTH || pos > store_count) begin
                    res.status = ST_REJECT;
                end else begin
                    for (i = store_count; i > pos; i--)
                        store_words[i] = store_words[i - 1];
                    store_words[pos] = val;
                    store_count++;
                    res.value = val;
                    res.index = IDX_W'(pos);
                end
                res.fill = CNT_W'(store_count);
                result_queue.push_back(res);
            end
            ACT_DELETE: begin
                if (pos >= store_count) begin
                    res.status = ST_REJECT;
                end else begin
                    res.value = store_words[pos];
                    res.index = IDX_W'(pos);
                    for (i = pos; i + 1 < store_count; i++)
                        store_words[i] = store_words[i + 1];
                    store_count--;
                end
                res.fill = CNT_W'(store_count);
                result_queue.push_back(res);
            end
            default: begin
                for (i = 0; i < store_count && !hit; i++) begin
                    if (store_words[i] == val) begin
                        hit       = 1'b1;
                        res.value = val;
                        res.index = IDX_W'(i);
                    end
                end
                if (!hit)
                    res.status = ST_MISS;
                res.fill = CNT_W'(store_count);
                result_queue.push_back(res);
            end
        endcase
    endtask

    // Send one action word; hold tvalid into the next word unless a gap follows
    task automatic send_action(t_action act, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
        i_s_axis_tdata  <= {{(S_DATA_W - VAL_W - POS_W){1'b0}}, pos, val};
        i_s_axis_tuser  <= act;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_action(act, val, pos);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold the sender until every predicted word has come back
    task automatic wait_drained(int settle);
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (result_queue.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return VAL_W'($urandom_range(7));  // force duplicates
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(string what, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected value=%h index=%0d status=%0d fill=%0d last=%b",
                     want.value, want.index, want.status, want.fill, want.last);
            $display("  actual   value=%h index=%0d status=%0d fill=%0d last=%b",
                     got.value, got.index, got.status, got.fill, got.last);
        end
    endtask

    // Check each accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value  = o_m_axis_tdata[VAL_W-1:0];
            got.index  = o_m_axis_tdata[VAL_W +: IDX_W];
            got.fill   = o_m_axis_tdata[VAL_W + IDX_W +: CNT_W];
            got.status = t_status'(o_m_axis_tuser);
            got.last   = o_m_axis_tlast;
            if (result_queue.size() == 0) begin
                want = '0;
                note_mismatch("result word with nothing expected", want, got);
            end else begin
                want = result_queue.pop_front();
                if (got.value !== want.value || got.index !== want.index ||
                    got.status !== want.status || got.fill !== want.fill ||
                    got.last !== want.last)
                    note_mismatch("result word mismatch", want, got);
            end
        end
    end

    // Empty store: empty traversal, miss, and every reject it allows
    task automatic test_empty_store();
        send_action(ACT_TRAVERSE, 32'h0, 7'd0);
        send_action(ACT_SEARCH, 32'h0, 7'd0);
        send_action(ACT_DELETE, 32'h0, 7'd0);
        send_action(ACT_DELETE, 32'hffff_ffff, 7'd64);
        send_action(ACT_INSERT, 32'h1234_5678, 7'd1);
        send_action(ACT_INSERT, 32'h1234_5678, 7'd64);
        wait_drained(0);
    endtask

    // Small store: extreme words, front/middle/end, duplicates, misses
    task automatic test_edge_values();
        send_action(ACT_INSERT, 32'h8000_0000, 7'd0);
        send_action(ACT_INSERT, 32'h7fff_ffff, 7'd1);
        send_action(ACT_INSERT, 32'h0000_0000, 7'd0);
        send_action(ACT_INSERT, 32'hffff_ffff, 7'd3);
        send_action(ACT_INSERT, 32'h0000_0005, 7'd2);
        send_action(ACT_INSERT, 32'hffff_ffff, 7'd0);
        send_action(ACT_TRAVERSE, 32'h0, 7'd0);
        send_action(ACT_SEARCH, 32'hffff_ffff, 7'd0);
        send_action(ACT_SEARCH, 32'h7fff_ffff, 7'd0);
        send_action(ACT_SEARCH, 32'h0000_3039, 7'd0);
        send_action(ACT_INSERT, 32'h0000_0001, 7'd7);
        send_action(ACT_DELETE, 32'h0, 7'd6);
        send_action(ACT_DELETE, 32'h0, 7'd2);
        send_action(ACT_DELETE, 32'h0, 7'd0);
        send_action(ACT_DELETE, 32'h0, 7'd3);
        send_action(ACT_TRAVERSE, 32'h0, 7'd0);
        wait_drained(0);
    endtask

    // Fill to capacity, then hit the full-store rejects and the top index
    task automatic test_full_store();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        while (store_count < STORE_DEPTH)
            send_action(ACT_INSERT, pick_value(), POS_W'($urandom_range(store_count)));
        send_action(ACT_INSERT, 32'h0000_00aa, 7'd0);
        send_action(ACT_INSERT, 32'h0000_00aa, 7'd64);
        send_action(ACT_TRAVERSE, 32'h0, 7'd0);
        send_action(ACT_SEARCH, store_words[STORE_DEPTH-1], 7'd0);
        send_action(ACT_DELETE, 32'h0, 7'd64);
        send_action(ACT_DELETE, 32'h0, 7'd63);
        send_action(ACT_INSERT, 32'h5a5a_a5a5, 7'd63);
        send_action(ACT_SEARCH, 32'h5a5a_a5a5, 7'd0);
        wait_drained(0);
    endtask

    // Mostly well-formed actions with some out-of-range positions
    task automatic test_random_mix(int idle_pct, int stall_pct, int n_items);
        t_action          act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        int               pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            pick = $urandom_range(99);
            val  = pick_value();
            pos  = POS_W'($urandom_range(STORE_DEPTH));
            if (pick < 10)
                act = ACT_TRAVERSE;
            else if (pick < 42)
                act = ACT_INSERT;
            else if (pick < 74)
                act = ACT_DELETE;
            else
                act = ACT_SEARCH;
            if ($urandom_range(99) >= 15) begin
                if (act == ACT_INSERT)
                    pos = POS_W'($urandom_range(store_count));
                else if (act == ACT_DELETE && store_count > 0)
                    pos = POS_W'($urandom_range(store_count - 1));
                else if (act == ACT_SEARCH && store_count > 0)
                    val = store_words[$urandom_range(store_count - 1)];
            end
            send_action(act, val, pos);
        end
        wait_drained(0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_edge_values();
        test_full_store();
        test_random_mix(0, 0, 10);
        test_random_mix(71, 0, 10);
        test_random_mix(0, 71, 10);
        test_random_mix(38, 38, 10);

        wait_drained(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/aids_pkg.sv
hdl/aids_ram.sv
hdl/array_insert_delete_search_core.sv
sim/testbench.sv
